>>> hw/rtl/bmp_pkg.sv
// shared types and constants for the bmp stream pixel decoder
// no dependencies
package bmp_pkg;

	localparam int unsigned MAX_WIDTH    = 4096;
	localparam int unsigned MAX_HEIGHT   = 4096;
	localparam int unsigned HEADER_BYTES = 54;
	localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;

	typedef enum logic [1:0] {
		KIND_PIXEL  = 2'd0,
		KIND_HEADER = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_SIG   = 3'd1,
		ST_COMPRESS  = 3'd2,
		ST_BAD_DEPTH = 3'd3,
		ST_TOO_LARGE = 3'd4,
		ST_BAD_OFFS  = 3'd5
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [23:0] pixel_address;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [12:0] image_width;
		logic [12:0] image_height;
		status_t     status;
		logic        last_pixel;
	} result_t;

	function automatic logic [31:0] magnitude(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

>>> hw/rtl/bmp_skid.sv
// two-entry output register with skid stage for decoder results
// depends on bmp_pkg
module bmp_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bmp_pkg::result_t push_data,
	output logic             ready,
	output logic             out_valid,
	input  logic             out_ready,
	output bmp_pkg::result_t out_data
);
	import bmp_pkg::*;

	logic    main_valid_q, skid_valid_q;
	result_t main_q, skid_q;
	logic    pop;

	assign pop       = main_valid_q && out_ready;
	assign ready     = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (push) begin
				main_q <= push_data;
			end else begin
				main_valid_q <= skid_valid_q;
				main_q       <= skid_q;
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q       <= push_data;
				skid_valid_q <= 1'b1;
			end else begin
				main_q       <= push_data;
				main_valid_q <= 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/bmp_parser.sv
// header parser and pixel sequencer, one byte per cycle while bytes are accepted
// depends on bmp_pkg
module bmp_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             first_byte,
	output logic             res_valid,
	output bmp_pkg::result_t res
);
	import bmp_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_SKIP,
		PH_PIXELS,
		PH_DONE
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [5:0]  idx_q, idx_d;
	logic [15:0] sig_q, sig_d;
	logic        comp_q, comp_d;
	logic [15:0] depth_q, depth_d;
	logic [31:0] width_q, width_d;
	logic [31:0] height_q, height_d;
	logic [31:0] offs_q, offs_d;
	logic [31:0] skip_q, skip_d;
	logic [14:0] rbyte_q, rbyte_d;
	logic [11:0] row_q, row_d;
	logic [23:0] base_q, base_d;
	logic [12:0] col_q, col_d;
	logic [1:0]  bip_q, bip_d;
	logic [7:0]  blue_q, blue_d;
	logic [7:0]  green_q, green_d;
	logic        topdown_q, topdown_d;

	// geometry derived from the header fields, settled well before header end
	logic [31:0] wmag_q, hmag_q;
	logic        big_q;
	logic [12:0] wm1_q;
	logic [11:0] hm1_q;
	logic [23:0] bottom_q;
	logic [14:0] rowdata_q, rowlast_q;
	logic [14:0] rowdata_c, rowround_c;

	phase_t      ph;
	logic [5:0]  idx;
	logic [5:0]  off_pos, w_pos, h_pos, d_pos;
	logic        bpp32;
	logic [1:0]  bip_last;

	function automatic logic [31:0] put_byte(input logic [31:0] r, input logic [7:0] b,
		input logic [1:0] pos);
		logic [31:0] v;
		v = r;
		case (pos)
			2'd0:    v[7:0]   = b;
			2'd1:    v[15:8]  = b;
			2'd2:    v[23:16] = b;
			default: v[31:24] = b;
		endcase
		return v;
	endfunction

	assign rowdata_c  = (depth_q == 16'd32) ? {wmag_q[12:0], 2'b00}
		: (15'(wmag_q[12:0]) + 15'({wmag_q[12:0], 1'b0}));
	assign rowround_c = (rowdata_q + 15'd3) & ~15'd3;

	always_ff @(posedge clk) begin
		wmag_q    <= magnitude(width_q);
		hmag_q    <= magnitude(height_q);
		big_q     <= (wmag_q > 32'(MAX_WIDTH)) || (hmag_q > 32'(MAX_HEIGHT));
		wm1_q     <= wmag_q[12:0] - 13'd1;
		hm1_q     <= 12'(hmag_q[12:0] - 13'd1);
		bottom_q  <= {12'd0, hm1_q} * {11'd0, wmag_q[12:0]};
		rowdata_q <= rowdata_c;
		rowlast_q <= rowround_c - 15'd1;
	end

	assign ph       = first_byte ? PH_HEADER : phase_q;
	assign idx      = first_byte ? 6'd0 : idx_q;
	assign off_pos  = idx - 6'd10;
	assign w_pos    = idx - 6'd18;
	assign h_pos    = idx - 6'd22;
	assign d_pos    = idx - 6'd28;
	assign bpp32    = (depth_q == 16'd32);
	assign bip_last = bpp32 ? 2'd3 : 2'd2;

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		sig_d     = sig_q;
		comp_d    = first_byte ? 1'b0 : comp_q;
		depth_d   = depth_q;
		width_d   = width_q;
		height_d  = height_q;
		offs_d    = offs_q;
		skip_d    = skip_q;
		rbyte_d   = rbyte_q;
		row_d     = row_q;
		base_d    = base_q;
		col_d     = col_q;
		bip_d     = bip_q;
		blue_d    = blue_q;
		green_d   = green_q;
		topdown_d = topdown_q;
		res_valid = 1'b0;
		res       = '0;
		res.kind  = KIND_PIXEL;
		res.status = ST_OK;

		case (ph)
			PH_HEADER: begin
				phase_d = PH_HEADER;
				if (idx < 6'd2) begin
					sig_d = idx[0] ? {data_byte, sig_q[7:0]} : {sig_q[15:8], data_byte};
				end else if (idx >= 6'd10 && idx < 6'd14) begin
					offs_d = put_byte(offs_q, data_byte, off_pos[1:0]);
				end else if (idx >= 6'd18 && idx < 6'd22) begin
					width_d = put_byte(width_q, data_byte, w_pos[1:0]);
				end else if (idx >= 6'd22 && idx < 6'd26) begin
					height_d = put_byte(height_q, data_byte, h_pos[1:0]);
				end else if (idx >= 6'd28 && idx < 6'd30) begin
					depth_d = d_pos[0] ? {data_byte, depth_q[7:0]} : {depth_q[15:8], data_byte};
				end else if (idx >= 6'd30 && idx < 6'd34 && data_byte != 8'd0) begin
					comp_d = 1'b1;
				end
				idx_d = idx + 6'd1;
				if (idx == 6'(HEADER_BYTES - 1)) begin
					res_valid = 1'b1;
					if (sig_q != BMP_SIGNATURE || comp_q
						|| (depth_q != 16'd24 && depth_q != 16'd32)
						|| big_q || offs_q < 32'(HEADER_BYTES)) begin
						phase_d  = PH_DONE;
						res.kind = KIND_ERROR;
						if (sig_q != BMP_SIGNATURE)                     res.status = ST_BAD_SIG;
						else if (comp_q)                                res.status = ST_COMPRESS;
						else if (depth_q != 16'd24 && depth_q != 16'd32) res.status = ST_BAD_DEPTH;
						else if (big_q)                                 res.status = ST_TOO_LARGE;
						else                                            res.status = ST_BAD_OFFS;
					end else begin
						topdown_d          = height_q[31];
						res.kind           = KIND_HEADER;
						res.image_width    = wmag_q[12:0];
						res.image_height   = hmag_q[12:0];
						if (wmag_q[12:0] == 13'd0 || hmag_q[12:0] == 13'd0) begin
							phase_d = PH_DONE;
						end else begin
							rbyte_d = '0;
							row_d   = '0;
							col_d   = '0;
							bip_d   = '0;
							base_d  = height_q[31] ? 24'd0 : bottom_q;
							skip_d  = offs_q - 32'(HEADER_BYTES);
							phase_d = (offs_q != 32'(HEADER_BYTES)) ? PH_SKIP : PH_PIXELS;
						end
					end
				end
			end
			PH_SKIP: begin
				skip_d = skip_q - 32'd1;
				if (skip_q == 32'd1) phase_d = PH_PIXELS;
			end
			PH_PIXELS: begin
				if (rbyte_q < rowdata_q) begin
					case (bip_q)
						2'd0: blue_d = data_byte;
						2'd1: green_d = data_byte;
						2'd2: begin
							res_valid         = 1'b1;
							res.kind          = KIND_PIXEL;
							res.pixel_address = base_q + 24'(col_q);
							res.red           = data_byte;
							res.green         = green_q;
							res.blue          = blue_q;
							res.last_pixel    = (row_q == hm1_q) && (col_q == wm1_q);
						end
						default: ;
					endcase
					if (bip_q == bip_last) begin
						bip_d = 2'd0;
						col_d = col_q + 13'd1;
					end else begin
						bip_d = bip_q + 2'd1;
					end
				end
				rbyte_d = rbyte_q + 15'd1;
				if (rbyte_q == rowlast_q) begin
					rbyte_d = '0;
					col_d   = '0;
					bip_d   = '0;
					if (row_q == hm1_q) begin
						phase_d = PH_DONE;
					end else begin
						row_d  = row_q + 12'd1;
						base_d = topdown_q ? base_q + 24'(wmag_q[12:0])
							: base_q - 24'(wmag_q[12:0]);
					end
				end
			end
			default: ;
		endcase
		if (!accept) res_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			idx_q     <= '0;
			sig_q     <= '0;
			comp_q    <= 1'b0;
			depth_q   <= '0;
			width_q   <= '0;
			height_q  <= '0;
			offs_q    <= '0;
			skip_q    <= '0;
			rbyte_q   <= '0;
			row_q     <= '0;
			base_q    <= '0;
			col_q     <= '0;
			bip_q     <= '0;
			blue_q    <= '0;
			green_q   <= '0;
			topdown_q <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			idx_q     <= idx_d;
			sig_q     <= sig_d;
			comp_q    <= comp_d;
			depth_q   <= depth_d;
			width_q   <= width_d;
			height_q  <= height_d;
			offs_q    <= offs_d;
			skip_q    <= skip_d;
			rbyte_q   <= rbyte_d;
			row_q     <= row_d;
			base_q    <= base_d;
			col_q     <= col_d;
			bip_q     <= bip_d;
			blue_q    <= blue_d;
			green_q   <= green_d;
			topdown_q <= topdown_d;
		end
	end

endmodule

>>> hw/rtl/bmp_stream_pixel_decoder.sv
// bmp stream pixel decoder top: one file byte per item in, header/error/pixel out
// depends on bmp_pkg, bmp_parser, bmp_skid
// a result is registered in the output skid before it appears on the master side
// throughput: one byte per cycle while the skid entry is free, else s_tready is low
// a two-entry output skid keeps the input open while one result waits
// reset: asynchronous, parser returns to idle and ignores bytes until a first byte
module bmp_stream_pixel_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte
	input  logic [0:0]  s_tuser,  // first_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // pixel_address, red, green, blue, image_width,
	                              // image_height, status, zero fill
	output logic [1:0]  m_tuser,  // result_kind
	output logic        m_tlast   // last_pixel
);
	import bmp_pkg::*;

	logic    accept;
	logic    res_valid;
	result_t res, out_res;

	assign accept = s_tvalid && s_tready;

	bmp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (s_tdata),
		.first_byte (s_tuser[0]),
		.res_valid  (res_valid),
		.res        (res)
	);

	bmp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.ready     (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {3'b000, out_res.status, out_res.image_height, out_res.image_width,
		out_res.blue, out_res.green, out_res.red, out_res.pixel_address};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last_pixel;

endmodule

>>> bench/bmp_stream_pixel_decoder_checker.sv
// checker for the bmp stream pixel decoder: watches both stream channels,
// predicts every result from the accepted file bytes and compares in order
// depends on bmp_pkg
module bmp_pixel_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte
	input  logic [0:0]  s_tuser,  // first_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,  // pixel_address, red, green, blue, image_width,
	                              // image_height, status, zero fill
	input  logic [1:0]  m_tuser,  // result_kind
	input  logic        m_tlast,  // last_pixel
	output int          errors,
	output int          pending
);
	import bmp_pkg::*;

	typedef enum logic [2:0] {
		P_IDLE,
		P_HEADER,
		P_SKIP,
		P_PIXELS,
		P_DONE
	} parse_t;

	parse_t      phase;
	logic [5:0]  hdr_idx;
	logic [15:0] sig_r;
	logic        comp_seen;
	logic [15:0] depth_r;
	logic [31:0] width_r;
	logic [31:0] height_r;
	logic [31:0] offs_r;
	logic [31:0] skip_left;
	logic [31:0] row_bytes;
	logic [31:0] row_num;
	logic [31:0] row_base;
	logic [31:0] col_num;
	logic [1:0]  pix_byte;
	logic [7:0]  blue_hold;
	logic [7:0]  green_hold;
	logic        top_down;

	result_t pixel_results[$];

	initial begin
		errors = 0;
		pending = 0;
		clear_decoder();
	end

	function automatic logic [31:0] abs_size(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	task automatic clear_decoder();
		phase = P_IDLE;
		hdr_idx = '0;
		sig_r = '0;
		comp_seen = 1'b0;
		depth_r = '0;
		width_r = '0;
		height_r = '0;
		offs_r = '0;
		skip_left = '0;
		row_bytes = '0;
		row_num = '0;
		row_base = '0;
		col_num = '0;
		pix_byte = '0;
		blue_hold = '0;
		green_hold = '0;
		top_down = 1'b0;
	endtask

	task automatic close_header(output bit got, output result_t r);
		logic [31:0] w;
		logic [31:0] h;
		status_t     st;
		w = abs_size(width_r);
		h = abs_size(height_r);
		r = '0;
		got = 1'b1;
		if (sig_r != BMP_SIGNATURE)
			st = ST_BAD_SIG;
		else if (comp_seen)
			st = ST_COMPRESS;
		else if (depth_r != 16'd24 && depth_r != 16'd32)
			st = ST_BAD_DEPTH;
		else if (w > MAX_WIDTH || h > MAX_HEIGHT)
			st = ST_TOO_LARGE;
		else if (offs_r < HEADER_BYTES)
			st = ST_BAD_OFFS;
		else
			st = ST_OK;
		if (st != ST_OK) begin
			phase = P_DONE;
			r.kind = KIND_ERROR;
			r.status = st;
		end else begin
			top_down = height_r[31];
			r.kind = KIND_HEADER;
			r.image_width = w[12:0];
			r.image_height = h[12:0];
			if (w == 0 || h == 0) begin
				phase = P_DONE;
			end else begin
				row_bytes = '0;
				row_num = '0;
				col_num = '0;
				pix_byte = '0;
				row_base = top_down ? 32'd0 : (h - 32'd1) * w;
				skip_left = offs_r - HEADER_BYTES;
				phase = (skip_left != 0) ? P_SKIP : P_PIXELS;
			end
		end
	endtask

	task automatic pixel_step(input logic [7:0] b, output bit got, output result_t r);
		logic [31:0] w;
		logic [31:0] h;
		logic [31:0] bpp;
		logic [31:0] row_data;
		logic [31:0] row_size;
		w = abs_size(width_r);
		h = abs_size(height_r);
		bpp = (depth_r == 16'd32) ? 32'd4 : 32'd3;
		row_data = w * bpp;
		row_size = row_data + ((32'd4 - (row_data & 32'd3)) & 32'd3);
		got = 1'b0;
		r = '0;
		if (row_bytes < row_data) begin
			if (pix_byte == 2'd0) begin
				blue_hold = b;
			end else if (pix_byte == 2'd1) begin
				green_hold = b;
			end else if (pix_byte == 2'd2) begin
				got = 1'b1;
				r.kind = KIND_PIXEL;
				r.pixel_address = row_base[23:0] + col_num[23:0];
				r.red = b;
				r.green = green_hold;
				r.blue = blue_hold;
				r.last_pixel = (row_num == h - 32'd1) && (col_num == w - 32'd1);
			end
			if (pix_byte == bpp[1:0] - 2'd1) begin
				pix_byte = '0;
				col_num++;
			end else begin
				pix_byte++;
			end
		end
		row_bytes++;
		if (row_bytes >= row_size) begin
			row_bytes = '0;
			col_num = '0;
			pix_byte = '0;
			if (row_num >= h - 32'd1) begin
				phase = P_DONE;
			end else begin
				row_num++;
				if (top_down)
					row_base = row_base + w;
				else
					row_base = row_base - w;
			end
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic first,
	                           output bit got, output result_t r);
		int i;
		got = 1'b0;
		r = '0;
		if (first) begin
			clear_decoder();
			phase = P_HEADER;
		end
		case (phase)
			P_HEADER: begin
				i = hdr_idx;
				if (i < 2)
					sig_r[i*8 +: 8] = b;
				else if (i >= 10 && i < 14)
					offs_r[(i-10)*8 +: 8] = b;
				else if (i >= 18 && i < 22)
					width_r[(i-18)*8 +: 8] = b;
				else if (i >= 22 && i < 26)
					height_r[(i-22)*8 +: 8] = b;
				else if (i >= 28 && i < 30)
					depth_r[(i-28)*8 +: 8] = b;
				else if (i >= 30 && i < 34 && b != 0)
					comp_seen = 1'b1;
				hdr_idx = hdr_idx + 6'd1;
				if (i >= HEADER_BYTES - 1)
					close_header(got, r);
			end
			P_SKIP: begin
				skip_left--;
				if (skip_left == 0)
					phase = P_PIXELS;
			end
			P_PIXELS: begin
				pixel_step(b, got, r);
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] seen);
		if (want !== seen) begin
			$error("%s expected %0d actual %0d", name, want, seen);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		bit      got;
		result_t r;
		result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, s_tuser[0], got, r);
				if (got)
					pixel_results.push_back(r);
			end
			if (m_tvalid && m_tready) begin
				if (pixel_results.size() == 0) begin
					$error("result with none expected: kind %0d data %h", m_tuser, m_tdata);
					errors++;
				end else begin
					want = pixel_results.pop_front();
					check_field("result_kind", want.kind, m_tuser);
					check_field("pixel_address", want.pixel_address, m_tdata[23:0]);
					check_field("red", want.red, m_tdata[31:24]);
					check_field("green", want.green, m_tdata[39:32]);
					check_field("blue", want.blue, m_tdata[47:40]);
					check_field("image_width", want.image_width, m_tdata[60:48]);
					check_field("image_height", want.image_height, m_tdata[73:61]);
					check_field("status", want.status, m_tdata[76:74]);
					check_field("last_pixel", want.last_pixel, m_tlast);
				end
			end
			pending = pixel_results.size();
		end
	end

endmodule

>>> bench/tb_bmp_stream_pixel_decoder.sv
// testbench top for the bmp stream pixel decoder: builds bmp files byte by byte
// with random idling on both sides; checking is done in bmp_pixel_checker
// depends on bmp_pkg, bmp_stream_pixel_decoder, bmp_pixel_checker
module tb_bmp_stream_pixel_decoder;
	import bmp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int errors;
	int pending;
	int idle_pct;
	int stall_pct;
	int file_count;
	int bytes_sent;

	localparam logic [15:0] SIG = BMP_SIGNATURE;

	bmp_stream_pixel_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	bmp_pixel_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("** bmp_stream_pixel_decoder: FAILED **");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic set_idle(input int ph);
		case (ph)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 59; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 59; end
			default: begin idle_pct = 6; stall_pct = 6; end
		endcase
	endtask

	// called and returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input bit first);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= first;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic stray_bytes(input int n, input int first_odds);
		for (int k = 0; k < n; k++)
			send_byte(8'($urandom), first_odds != 0 && $urandom_range(0, first_odds - 1) == 0);
	endtask

	// cut > 0 stops the file early so that the next file restarts the parser
	task automatic send_file(input logic [15:0] sig, input logic [31:0] offs,
	                         input logic [31:0] wd, input logic [31:0] ht,
	                         input logic [15:0] depth, input logic [31:0] comp,
	                         input int extra, input int cut);
		logic [7:0]  hdr[54];
		logic [31:0] aw;
		logic [31:0] ah;
		logic [31:0] row_size;
		int          total;
		set_idle(file_count % 4);
		file_count++;
		foreach (hdr[k])
			hdr[k] = 8'($urandom);
		hdr[0] = sig[7:0];
		hdr[1] = sig[15:8];
		for (int k = 0; k < 4; k++) begin
			hdr[10+k] = offs[k*8 +: 8];
			hdr[18+k] = wd[k*8 +: 8];
			hdr[22+k] = ht[k*8 +: 8];
			hdr[30+k] = comp[k*8 +: 8];
		end
		hdr[28] = depth[7:0];
		hdr[29] = depth[15:8];
		aw = wd[31] ? 32'd0 - wd : wd;
		ah = ht[31] ? 32'd0 - ht : ht;
		row_size = ((aw * ((depth == 16'd32) ? 32'd4 : 32'd3) + 32'd3) / 32'd4) * 32'd4;
		total = 54 + extra;
		if (aw <= 4096 && ah <= 4096 && offs >= 54 && offs <= 54 + 64)
			total += (offs - 54) + row_size * ah;
		if (cut > 0 && cut < total)
			total = cut;
		for (int k = 0; k < total; k++)
			send_byte(k < 54 ? hdr[k] : 8'($urandom), k == 0);
		bytes_sent += total;
	endtask

	task automatic random_file();
		logic [15:0] sig;
		logic [15:0] depth;
		logic [31:0] offs;
		logic [31:0] wd;
		logic [31:0] ht;
		logic [31:0] comp;
		int          cut;
		sig = SIG;
		comp = '0;
		depth = $urandom_range(0, 1) ? 16'd32 : 16'd24;
		wd = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
		ht = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 4);
		offs = 54 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
		if ($urandom_range(0, 1))
			ht = 32'd0 - ht;
		if ($urandom_range(0, 5) == 0)
			wd = 32'd0 - wd;
		if ($urandom_range(0, 99) < 15) begin
			case ($urandom_range(0, 4))
				0: sig = 16'($urandom);
				1: comp = $urandom;
				2: depth = 16'($urandom);
				3: wd = $urandom_range(0, 1) ? $urandom : 4097 + $urandom_range(0, 9);
				default: offs = $urandom_range(0, 53);
			endcase
		end
		cut = ($urandom_range(0, 99) < 10) ? $urandom_range(1, 120) : 0;
		send_file(sig, offs, wd, ht, depth, comp, $urandom_range(0, 3), cut);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		idle_pct = 0;
		stall_pct = 0;
		file_count = 0;
		bytes_sent = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// bytes before any file are ignored
		stray_bytes(3, 0);
		// several faults, lowest code wins
		send_file(16'h1234, 54, 2, 2, 16, 1, 0, 0);
		send_file(SIG, 54, 2, 2, 8, 32'h0000_0100, 0, 0);
		send_file(SIG, 54, 2, 2, 16, 0, 0, 0);
		send_file(SIG, 54, 4097, 1, 24, 0, 0, 0);
		send_file(SIG, 54, 1, 32'h8000_0000, 24, 0, 0, 0);
		send_file(SIG, 53, 1, 1, 32, 0, 2, 0);
		send_file(SIG, 0, 1, 1, 24, 0, 0, 0);
		// empty images
		send_file(SIG, 54, 0, 3, 24, 0, 2, 0);
		send_file(SIG, 54, 3, 0, 32, 0, 0, 0);
		// restart inside the header and inside the pixel data
		send_file(SIG, 54, 3, 2, 24, 0, 0, 40);
		send_file(SIG, 54, 3, 2, 24, 0, 0, 62);
		send_file(SIG, 60, 2, -2, 32, 0, 3, 0);
		send_file(SIG, 54, 3, 2, 24, 0, 0, 0);
		send_file(SIG, 54, -5, 3, 24, 0, 0, 0);
		stray_bytes(4, 0);
		drain();
		// widest and tallest images, first pixels only
		send_file(SIG, 54, 4096, -1, 32, 0, 0, 54 + 64);
		send_file(SIG, 54, 1, 4096, 24, 0, 1, 54 + 64);
		drain();

		bytes_sent = 0;
		while (bytes_sent < 400) begin
			if ($urandom_range(0, 99) < 8)
				stray_bytes($urandom_range(1, 20), 20);
			random_file();
			if ($urandom_range(0, 19) == 0)
				drain();
		end

		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		if (errors == 0)
			$display("** bmp_stream_pixel_decoder: PASSED **");
		else
			$display("** bmp_stream_pixel_decoder: FAILED **");
		$finish;
	end

endmodule
